FILE: rtl/homogeneous_vector_transform_macros.svh
// assertion macros for the homogeneous vector transform
`ifndef HOMOGENEOUS_VECTOR_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_VECTOR_TRANSFORM_MACROS_SVH
`ifndef SYNTHESIS
`define HVT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hvt assertion failed");
`define HVT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hvt assertion failed");
`else
`define HVT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HVT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/hvt_pkg.sv
// shared constants and types for the homogeneous vector transform
`timescale 1ns / 1ps
package hvt_pkg;
    localparam int DIM       = 4;
    localparam int VAL_W     = 32;
    localparam int ROW_W     = DIM * VAL_W;
    localparam int IDX_W     = $clog2(DIM);
    localparam int DIV_NUM_W = VAL_W + 16;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_VEC   = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;

    localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                    done;
        logic                    sat;
        logic signed [VAL_W-1:0] quo;
    } div_res_t;
endpackage

FILE: rtl/hvt_mat_ram.sv
// matrix store: one row per word, element write lanes, registered read
`timescale 1ns / 1ps
module hvt_mat_ram (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [hvt_pkg::IDX_W-1:0]       wr_row,
    input  logic [hvt_pkg::IDX_W-1:0]       wr_col,
    input  logic [hvt_pkg::VAL_W-1:0]       wr_data,
    input  logic                            rd_en,
    input  logic [hvt_pkg::IDX_W-1:0]       rd_row,
    output logic [hvt_pkg::ROW_W-1:0]       rd_data
);
    logic [hvt_pkg::ROW_W-1:0] mem [hvt_pkg::DIM];
    logic [hvt_pkg::DIM-1:0]   valid_reg [hvt_pkg::DIM];
    logic [hvt_pkg::ROW_W-1:0] raw_reg;
    logic [hvt_pkg::DIM-1:0]   rvld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_col*hvt_pkg::VAL_W +: hvt_pkg::VAL_W] <= wr_data;
        end
        if (rd_en) begin
            raw_reg <= mem[rd_row];
        end
    end

    // elements never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < hvt_pkg::DIM; r++) begin
                valid_reg[r] <= '0;
            end
            rvld_reg <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_row][wr_col] <= 1'b1;
            end
            if (rd_en) begin
                rvld_reg <= valid_reg[rd_row];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < hvt_pkg::DIM; c++) begin
            rd_data[c*hvt_pkg::VAL_W +: hvt_pkg::VAL_W] =
                rvld_reg[c] ? raw_reg[c*hvt_pkg::VAL_W +: hvt_pkg::VAL_W] : '0;
        end
    end
endmodule

FILE: rtl/hvt_div.sv
// radix-2 restoring divider for the point divide, saturating to 32 bits
`timescale 1ns / 1ps
module hvt_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [hvt_pkg::DIV_NUM_W-1:0]   num,
    input  logic signed [hvt_pkg::VAL_W-1:0]       den,
    output logic                                   busy,
    output hvt_pkg::div_res_t                      res
);
    localparam int NW  = hvt_pkg::DIV_NUM_W;
    localparam int DW  = hvt_pkg::VAL_W;
    localparam int CW  = $clog2(NW);
    localparam logic [CW-1:0] LAST = CW'(NW - 1);

    logic          busy_reg, done_reg, neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] n_reg, q_reg;
    logic [DW-1:0] d_reg, rem_reg;
    logic [DW:0]   rem_sh, rem_sub;

    assign rem_sh  = {rem_reg, n_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                n_reg    <= num[NW-1] ? NW'(-num) : NW'(num);
                d_reg    <= den[DW-1] ? DW'(-den) : DW'(den);
                neg_reg  <= num[NW-1] ^ den[DW-1];
                rem_reg  <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                n_reg <= {n_reg[NW-2:0], 1'b0};
                if (rem_sh >= {1'b0, d_reg}) begin
                    rem_reg <= rem_sub[DW-1:0];
                    q_reg   <= {q_reg[NW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[DW-1:0];
                    q_reg   <= {q_reg[NW-2:0], 1'b0};
                end
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;

    always_comb begin
        res.done = done_reg;
        res.sat  = 1'b0;
        if (neg_reg) begin
            if (q_reg > NW'({1'b1, {(DW-1){1'b0}}})) begin
                res.sat = 1'b1;
                res.quo = hvt_pkg::VAL_MIN;
            end else begin
                res.quo = DW'(-q_reg);
            end
        end else begin
            if (q_reg > NW'({1'b0, {(DW-1){1'b1}}})) begin
                res.sat = 1'b1;
                res.quo = hvt_pkg::VAL_MAX;
            end else begin
                res.quo = q_reg[DW-1:0];
            end
        end
    end
endmodule

FILE: rtl/homogeneous_vector_transform.sv
// top level of the homogeneous 4x4 matrix-vector transform
`timescale 1ns / 1ps
`include "homogeneous_vector_transform_macros.svh"
// homogeneous 4x4 transform in signed q16.16. the matrix sits in a 4-row memory,
// all zero after reset. a load word (tuser 0) writes one element and gives no
// result; tuser 3 is dropped. a vector word (tuser 1) reads one matrix row per
// cycle into four multipliers. a point word (tuser 2) uses w = 1.0 and then
// divides x, y and z by the product w in a 1-bit-per-cycle divider, 48 steps
// each; a zero w skips the divide. one word is worked at a time; a new word is
// taken while a finished result still waits in the output register.
module homogeneous_vector_transform (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // row_sel[1:0], col_sel[3:2], in_x[35:4], in_y[67:36], in_z[99:68],
    // in_w[131:100], zero pad
    input  logic [135:0] s_tdata,
    // op[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [127:0] m_tdata,
    // w_zero[0], saturated[1]
    output logic [1:0]   m_tuser
);
    localparam int VW = hvt_pkg::VAL_W;
    localparam int D  = hvt_pkg::DIM;
    localparam int IW = hvt_pkg::IDX_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // mac schedule: rows read at steps 0..3, all sums stored by step 6
    localparam logic [2:0] MAC_DONE = 3'd6;

    logic [1:0]              state_reg;
    logic [2:0]              cnt_reg;
    logic                    point_reg;
    logic signed [VW-1:0]    vec_reg [D];
    logic signed [VW-1:0]    res_reg [D];
    logic                    sat_reg, wz_reg;

    // pipeline tags for the memory read and multiplier stages
    logic                    rd_vld_reg, p_vld_reg;
    logic [IW-1:0]           rd_row_reg, p_row_reg;
    logic signed [2*VW-1:0]  prod_reg [D];

    logic                    accept, out_load;
    logic                    ram_wr, ram_rd;
    logic [hvt_pkg::ROW_W-1:0] ram_q;

    // divider sequencing
    logic                    div_go_reg;
    logic [1:0]              div_idx_reg;
    logic                    div_busy;
    hvt_pkg::div_res_t       div_res;

    logic                    m_tvalid_reg;
    logic [127:0]            m_data_reg;
    logic [1:0]              m_user_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign ram_wr   = accept && (s_tuser == hvt_pkg::OP_LOAD);
    assign ram_rd   = (state_reg == S_MAC) && !cnt_reg[2];
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    hvt_mat_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ram_wr),
        .wr_row  (s_tdata[1:0]),
        .wr_col  (s_tdata[3:2]),
        .wr_data (s_tdata[35:4]),
        .rd_en   (ram_rd),
        .rd_row  (cnt_reg[IW-1:0]),
        .rd_data (ram_q)
    );

    hvt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go_reg),
        .num     ({res_reg[div_idx_reg], 16'h0000}),
        .den     (res_reg[D-1]),
        .busy    (div_busy),
        .res     (div_res)
    );

    // multiply stage: one row times the vector
    always_ff @(posedge aclk) begin
        for (int c = 0; c < D; c++) begin
            prod_reg[c] <= $signed(ram_q[c*VW +: VW]) * vec_reg[c];
        end
        p_row_reg <= rd_row_reg;
        rd_row_reg <= cnt_reg[IW-1:0];
    end

    // exact row sum, floor shift by 16, clamp to 32 bits
    logic signed [2*VW+1:0] acc;
    logic signed [2*VW-15:0] acc_sh;
    logic signed [VW-1:0]   row_val;
    logic                   row_sat;
    always_comb begin
        acc = '0;
        for (int c = 0; c < D; c++) begin
            acc = acc + (2*VW+2)'(prod_reg[c]);
        end
        acc_sh  = $signed(acc[2*VW+1:16]);
        row_sat = 1'b0;
        if (acc_sh > (2*VW-14)'(hvt_pkg::VAL_MAX)) begin
            row_val = hvt_pkg::VAL_MAX;
            row_sat = 1'b1;
        end else if (acc_sh < (2*VW-14)'(hvt_pkg::VAL_MIN)) begin
            row_val = hvt_pkg::VAL_MIN;
            row_sat = 1'b1;
        end else begin
            row_val = acc_sh[VW-1:0];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            vec_reg[0] <= s_tdata[35:4];
            vec_reg[1] <= s_tdata[67:36];
            vec_reg[2] <= s_tdata[99:68];
            vec_reg[3] <= (s_tuser == hvt_pkg::OP_POINT) ? hvt_pkg::ONE_Q16 : s_tdata[131:100];
            point_reg  <= (s_tuser == hvt_pkg::OP_POINT);
        end
        if (p_vld_reg) begin
            res_reg[p_row_reg] <= row_val;
        end
        if (state_reg == S_MAC && cnt_reg == MAC_DONE && point_reg && res_reg[D-1] == '0) begin
            res_reg[0] <= '0;
            res_reg[1] <= '0;
            res_reg[2] <= '0;
        end
        if (state_reg == S_DIV && div_res.done) begin
            res_reg[div_idx_reg] <= div_res.quo;
        end
        if (out_load) begin
            m_data_reg <= {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
            m_user_reg <= {sat_reg, wz_reg};
        end
    end

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            p_vld_reg    <= 1'b0;
            div_go_reg   <= 1'b0;
            div_idx_reg  <= '0;
            sat_reg      <= 1'b0;
            wz_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= ram_rd;
            p_vld_reg  <= rd_vld_reg;
            div_go_reg <= 1'b0;
            if (p_vld_reg) begin
                sat_reg <= sat_reg | row_sat;
            end
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept && (s_tuser == hvt_pkg::OP_VEC || s_tuser == hvt_pkg::OP_POINT)) begin
                        state_reg <= S_MAC;
                        cnt_reg   <= '0;
                        sat_reg   <= 1'b0;
                        wz_reg    <= 1'b0;
                    end
                end
                S_MAC: begin
                    if (cnt_reg == MAC_DONE) begin
                        if (!point_reg) begin
                            state_reg <= S_OUT;
                        end else if (res_reg[D-1] == '0) begin
                            wz_reg    <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            div_idx_reg <= '0;
                            div_go_reg  <= 1'b1;
                            state_reg   <= S_DIV;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        sat_reg <= sat_reg | div_res.sat;
                        if (div_idx_reg == 2'd2) begin
                            state_reg <= S_OUT;
                        end else begin
                            div_idx_reg <= div_idx_reg + 1'b1;
                            div_go_reg  <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // a result word never overwrites one still waiting
    `HVT_ASSERT_IMP(a_no_overwrite, aclk, aresetn, out_load, !m_tvalid_reg || m_tready)
    // no new word is taken while the divider still runs
    `HVT_ASSERT_IMP(a_idle_div, aclk, aresetn, s_tready, !div_busy && !div_go_reg)
    // a zero w result carries zero x, y and z
    `HVT_ASSERT_IMP(a_wz_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[95:0] == '0)
    // a divider start is followed by a busy divider
    `HVT_ASSERT_NXT(a_div_run, aclk, aresetn, div_go_reg, div_busy)
endmodule
